// ===== rtl/gcb_pkg.sv =====
// Shared constants, types and the arctangent table for the bearing pipeline.
package gcb_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int CORDIC_MAX        = 32;

  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int BRG_W = 25;
  localparam int ANG_W = 36;   // Q32 radians
  localparam int XY_W  = 34;   // Q30 CORDIC vectors
  localparam int SC_W  = 32;   // Q30 sine / cosine

  localparam logic signed [ANG_W-1:0] PI_Q32      = 36'sd13493037704;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q32  = 36'sd26986075409;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q32 = 36'sd6746518852;
  localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;
  localparam logic signed [XY_W-1:0]  ONE_Q30     = 34'sd1073741824;
  localparam logic signed [28:0]      DEG_PER_RAD = 29'sd240315917;
  localparam logic [BRG_W:0]          FULL_CIRCLE = 26'd23592960;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [XY_W-1:0]  xy_t;
  typedef logic signed [SC_W-1:0]  sc_t;

  function automatic ang_t atan_q32(input int i);
    ang_t r;
    case (i)
      0:  r = 36'sd3373259426;
      1:  r = 36'sd1991351316;
      2:  r = 36'sd1052175347;
      3:  r = 36'sd534100635;
      4:  r = 36'sd268086748;
      5:  r = 36'sd134174063;
      6:  r = 36'sd67103403;
      7:  r = 36'sd33553749;
      8:  r = 36'sd16777131;
      9:  r = 36'sd8388597;
      10: r = 36'sd4194303;
      11: r = 36'sd2097152;
      12: r = 36'sd1048576;
      13: r = 36'sd524288;
      14: r = 36'sd262144;
      15: r = 36'sd131072;
      16: r = 36'sd65536;
      17: r = 36'sd32768;
      18: r = 36'sd16384;
      19: r = 36'sd8192;
      20: r = 36'sd4096;
      21: r = 36'sd2048;
      22: r = 36'sd1024;
      23: r = 36'sd512;
      24: r = 36'sd256;
      25: r = 36'sd128;
      26: r = 36'sd64;
      27: r = 36'sd32;
      28: r = 36'sd16;
      29: r = 36'sd8;
      30: r = 36'sd4;
      31: r = 36'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/gcb_in_if.sv =====
// Request channel carrying the two positions.
interface gcb_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [gcb_pkg::LAT_W-1:0]   start_latitude;
  logic signed [gcb_pkg::LON_W-1:0]   start_longitude;
  logic signed [gcb_pkg::LAT_W-1:0]   end_latitude;
  logic signed [gcb_pkg::LON_W-1:0]   end_longitude;

  modport source (output valid, start_latitude, start_longitude, end_latitude,
                  end_longitude, input ready);
  modport sink   (input valid, start_latitude, start_longitude, end_latitude,
                  end_longitude, output ready);
endinterface

// ===== rtl/gcb_out_if.sv =====
// Result channel carrying the bearing.
interface gcb_out_if;
  logic                        valid;
  logic                        ready;
  logic [gcb_pkg::BRG_W-1:0]   bearing_degrees;

  modport source (output valid, bearing_degrees, input ready);
  modport sink   (input valid, bearing_degrees, output ready);
endinterface

// ===== rtl/gcb_rot_cordic.sv =====
// Pipelined angle reduction and rotation CORDIC giving sine and cosine.
module gcb_rot_cordic #(
  parameter int STAGES = gcb_pkg::CORDIC_STAGES_DEF
) (
  input  logic           clk,
  input  logic           en,
  input  gcb_pkg::ang_t  angle_i,
  output gcb_pkg::sc_t   sin_o,
  output gcb_pkg::sc_t   cos_o
);

  localparam int ITER = (STAGES > gcb_pkg::CORDIC_MAX) ? gcb_pkg::CORDIC_MAX : STAGES;

  gcb_pkg::ang_t mod_r, wrap_r;
  gcb_pkg::ang_t z_r [ITER+1];
  gcb_pkg::xy_t  x_r [ITER+1];
  gcb_pkg::xy_t  y_r [ITER+1];
  logic          f_r [ITER+1];
  gcb_pkg::sc_t  sin_r, cos_r;
  gcb_pkg::xy_t  xc, yc;

  // reduce modulo 2*pi (truncating), then into [-pi, pi], then fold half turns
  always_ff @(posedge clk) begin
    if (en) begin
      if (angle_i >= gcb_pkg::TWO_PI_Q32) begin
        mod_r <= angle_i - gcb_pkg::TWO_PI_Q32;
      end else if (angle_i <= -gcb_pkg::TWO_PI_Q32) begin
        mod_r <= angle_i + gcb_pkg::TWO_PI_Q32;
      end else begin
        mod_r <= angle_i;
      end
      if (mod_r > gcb_pkg::PI_Q32) begin
        wrap_r <= mod_r - gcb_pkg::TWO_PI_Q32;
      end else if (mod_r < -gcb_pkg::PI_Q32) begin
        wrap_r <= mod_r + gcb_pkg::TWO_PI_Q32;
      end else begin
        wrap_r <= mod_r;
      end
      x_r[0] <= gcb_pkg::GAIN_Q30;
      y_r[0] <= '0;
      if (wrap_r > gcb_pkg::HALF_PI_Q32) begin
        z_r[0] <= wrap_r - gcb_pkg::PI_Q32;
        f_r[0] <= 1'b1;
      end else if (wrap_r < -gcb_pkg::HALF_PI_Q32) begin
        z_r[0] <= wrap_r + gcb_pkg::PI_Q32;
        f_r[0] <= 1'b1;
      end else begin
        z_r[0] <= wrap_r;
        f_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - gcb_pkg::atan_q32(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + gcb_pkg::atan_q32(i);
        end
      end
    end
  end

  always_comb begin
    xc = x_r[ITER];
    yc = y_r[ITER];
    if (xc > gcb_pkg::ONE_Q30) xc = gcb_pkg::ONE_Q30;
    if (xc < -gcb_pkg::ONE_Q30) xc = -gcb_pkg::ONE_Q30;
    if (yc > gcb_pkg::ONE_Q30) yc = gcb_pkg::ONE_Q30;
    if (yc < -gcb_pkg::ONE_Q30) yc = -gcb_pkg::ONE_Q30;
    if (f_r[ITER]) begin
      xc = -xc;
      yc = -yc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= yc[gcb_pkg::SC_W-1:0];
      cos_r <= xc[gcb_pkg::SC_W-1:0];
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ===== rtl/gcb_vec_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(e, n) in Q32 radians.
module gcb_vec_cordic #(
  parameter int STAGES = gcb_pkg::CORDIC_STAGES_DEF
) (
  input  logic           clk,
  input  logic           en,
  input  gcb_pkg::xy_t   e_i,
  input  gcb_pkg::xy_t   n_i,
  input  logic           zero_i,
  output gcb_pkg::ang_t  ang_o,
  output logic           zero_o
);

  localparam int ITER = (STAGES > gcb_pkg::CORDIC_MAX) ? gcb_pkg::CORDIC_MAX : STAGES;

  gcb_pkg::ang_t vx_r [ITER+1];
  gcb_pkg::ang_t vy_r [ITER+1];
  gcb_pkg::ang_t z_r  [ITER+1];
  logic          zf_r [ITER+1];
  gcb_pkg::ang_t ex, nx;

  assign ex = gcb_pkg::ang_t'(e_i);
  assign nx = gcb_pkg::ang_t'(n_i);

  // quarter-turn prerotation into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zf_r[0] <= zero_i;
      if (nx < 0) begin
        if (ex >= 0) begin
          vx_r[0] <= ex;
          vy_r[0] <= -nx;
          z_r[0]  <= gcb_pkg::HALF_PI_Q32;
        end else begin
          vx_r[0] <= -ex;
          vy_r[0] <= nx;
          z_r[0]  <= -gcb_pkg::HALF_PI_Q32;
        end
      end else begin
        vx_r[0] <= nx;
        vy_r[0] <= ex;
        z_r[0]  <= '0;
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zf_r[i+1] <= zf_r[i];
        if (vy_r[i] > 0) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          z_r[i+1]  <= z_r[i] + gcb_pkg::atan_q32(i);
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          z_r[i+1]  <= z_r[i] - gcb_pkg::atan_q32(i);
        end
      end
    end
  end

  assign ang_o  = z_r[ITER];
  assign zero_o = zf_r[ITER];

endmodule

// ===== rtl/great_circle_bearing.sv =====
// Top level: pipelined initial great-circle bearing between two positions.
//
// Usage:
//   in_ch  (sink)   : one request per pair of positions, lat in Q2.29 and lon in Q3.29 radians.
//   out_ch (source) : one bearing per request, unsigned, 1/65536 degree, [0, 360).
//   A request is taken on a clock edge with valid and ready both high.
// Pipeline: from request to result valid, the path runs through the two CORDIC
//   pipelines (24 stages each by default), one register per iteration, plus
//   reduction, three multiply stages, degree scaling and the output
//   register.
// Throughput: one request per cycle while out_ch.ready stays high.
// Stall: when out_ch.ready is low the waiting result holds; one more result
//   lands in a skid register, then in_ch.ready drops and the whole pipeline
//   freezes in place. Nothing is dropped or duplicated.
// Reset: rst_n (synchronous, active low) clears every valid bit; the block
//   holds no other control state, so it accepts a request on the first cycle after.
module great_circle_bearing #(
  parameter int CORDIC_STAGES = gcb_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gcb_in_if.sink      in_ch,
  gcb_out_if.source   out_ch
);

  localparam int ITER = (CORDIC_STAGES > gcb_pkg::CORDIC_MAX) ?
                        gcb_pkg::CORDIC_MAX : CORDIC_STAGES;
  // S0 + rotation (ITER+4) + three product stages + vectoring (ITER+1) + two scaling
  localparam int LAT = 2 * ITER + 11;

  logic adv;                     // pipeline advance: skid slot is free
  logic v_r [LAT];

  // stage 0: Q32 angles
  gcb_pkg::ang_t lat_a_r, lat_b_r, dlon_r;
  logic signed [gcb_pkg::LON_W:0] dlon_q29;

  gcb_pkg::sc_t sa, ca, sb, cb, sd, cd;

  // product stages
  logic signed [63:0] p_sdcb, p_casb, p_sacb, p_tcd;
  gcb_pkg::xy_t east1_r, casb1_r, east2_r, casb2_r, u2_r, east3_r, north3_r;
  gcb_pkg::sc_t sacb1_r, cd1_r;
  gcb_pkg::xy_t north_c;
  logic         zero3_r;

  gcb_pkg::ang_t ang;
  logic          zero_v;

  // degree scaling
  logic signed [63:0] deg_prod_r, deg_sum;
  logic               zero_d1_r;
  logic signed [gcb_pkg::BRG_W:0] deg;
  logic [gcb_pkg::BRG_W:0]        wrapped;
  logic [gcb_pkg::BRG_W-1:0]      res_r;

  // output register and skid
  logic                      out_v_r, skid_v_r;
  logic [gcb_pkg::BRG_W-1:0] out_r, skid_r;

  assign adv         = !skid_v_r;
  assign in_ch.ready = adv;

  // valid bits, one per pipeline stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_ch.valid;
      for (int k = 1; k < LAT; k++) v_r[k] <= v_r[k-1];
    end
  end

  // longitude difference in Q4.29, one bit wider than the inputs
  assign dlon_q29 = {in_ch.end_longitude[gcb_pkg::LON_W-1], in_ch.end_longitude}
                  - {in_ch.start_longitude[gcb_pkg::LON_W-1], in_ch.start_longitude};

  // times 8 takes Q29 to Q32
  always_ff @(posedge clk) begin
    if (adv) begin
      lat_a_r <= {{2{in_ch.start_latitude[gcb_pkg::LAT_W-1]}}, in_ch.start_latitude, 3'b000};
      lat_b_r <= {{2{in_ch.end_latitude[gcb_pkg::LAT_W-1]}}, in_ch.end_latitude, 3'b000};
      dlon_r  <= {dlon_q29, 3'b000};
    end
  end

  gcb_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_a (
    .clk(clk), .en(adv), .angle_i(lat_a_r), .sin_o(sa), .cos_o(ca));
  gcb_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_b (
    .clk(clk), .en(adv), .angle_i(lat_b_r), .sin_o(sb), .cos_o(cb));
  gcb_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_d (
    .clk(clk), .en(adv), .angle_i(dlon_r), .sin_o(sd), .cos_o(cd));

  // east and north terms; every product floored back to Q30
  assign p_sdcb = 64'(sd) * 64'(cb);
  assign p_casb = 64'(ca) * 64'(sb);
  assign p_sacb = 64'(sa) * 64'(cb);
  assign p_tcd  = 64'(sacb1_r) * 64'(cd1_r);

  assign north_c = casb2_r - u2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      east1_r  <= p_sdcb[30 +: gcb_pkg::XY_W];
      casb1_r  <= p_casb[30 +: gcb_pkg::XY_W];
      sacb1_r  <= p_sacb[30 +: gcb_pkg::SC_W];
      cd1_r    <= cd;
      east2_r  <= east1_r;
      casb2_r  <= casb1_r;
      u2_r     <= p_tcd[30 +: gcb_pkg::XY_W];
      east3_r  <= east2_r;
      north3_r <= north_c;
      zero3_r  <= (east2_r == '0) && (north_c == '0);
    end
  end

  gcb_vec_cordic #(.STAGES(CORDIC_STAGES)) u_vec (
    .clk(clk), .en(adv), .e_i(east3_r), .n_i(north3_r), .zero_i(zero3_r),
    .ang_o(ang), .zero_o(zero_v));

  // degrees times 65536, rounded half up, then wrapped onto the full circle
  assign deg_sum = deg_prod_r + 64'sd137438953472;
  assign deg     = deg_sum[38 +: gcb_pkg::BRG_W+1];
  assign wrapped = deg[gcb_pkg::BRG_W] ? (gcb_pkg::BRG_W+1)'(deg) + gcb_pkg::FULL_CIRCLE
                                       : (gcb_pkg::BRG_W+1)'(deg);

  always_ff @(posedge clk) begin
    if (adv) begin
      deg_prod_r <= 64'(ang) * 64'(gcb_pkg::DEG_PER_RAD);
      zero_d1_r  <= zero_v;
      res_r      <= zero_d1_r ? '0 : wrapped[gcb_pkg::BRG_W-1:0];
    end
  end

  // output register with one skid slot behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_ch.ready) begin
      if (adv && v_r[LAT-1]) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= v_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_ch.ready) begin
      if (adv && v_r[LAT-1]) skid_r <= res_r;
    end else if (skid_v_r) begin
      out_r <= skid_r;
    end else begin
      out_r <= res_r;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.bearing_degrees = out_r;

`ifndef SYNTHESIS
  // the skid slot is only ever filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid full with output empty");

  a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid filled without a stall");

  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ({1'b0, out_r} < gcb_pkg::FULL_CIRCLE))
    else $error("bearing outside full circle");
`endif

endmodule
